FILE: design/rbd_pkg.sv
// Shared constants, mode codes and control types for the 2x2 RGB downsampler.
`timescale 1ns / 1ps
package rbd_pkg;

	localparam int MAX_SIZE   = 1024;
	localparam int PAIR_DEPTH = MAX_SIZE / 2;
	localparam int CNT_W      = $clog2(MAX_SIZE);
	localparam int IDX_W      = $clog2(PAIR_DEPTH);
	localparam int SIZE_W     = CNT_W + 1;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int SUM_CH_W   = CH_W + 1;
	localparam int SUM_W      = 3 * SUM_CH_W;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_QUAD = 2'd0;
	localparam mode_t MODE_HORZ = 2'd1;
	localparam mode_t MODE_VERT = 2'd2;
	localparam mode_t MODE_ONE  = 2'd3;

	typedef struct packed {
		logic  emit;
		logic  last;
		mode_t mode;
	} ctrl_t;

endpackage

FILE: design/rbd_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module rbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

FILE: design/rbd_seq.sv
// Frame position counters, size registers and per-pixel action decode.
`timescale 1ns / 1ps
module rbd_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           accept,
	input  logic [rbd_pkg::PIX_W-1:0]      pixel,
	output rbd_pkg::ctrl_t                 ctrl,
	output logic [rbd_pkg::PIX_W-1:0]      left_pixel,
	output logic                           mem_we,
	output logic                           mem_re,
	output logic [rbd_pkg::IDX_W-1:0]      mem_addr,
	output logic [rbd_pkg::SUM_W-1:0]      mem_wdata
);

	localparam int EXT_W = (rbd_pkg::CFG_W > rbd_pkg::SIZE_W) ? rbd_pkg::CFG_W
		: rbd_pkg::SIZE_W;

	logic [rbd_pkg::SIZE_W-1:0] width_q, height_q, size_eff;
	logic [rbd_pkg::CNT_W-1:0]  col_q, row_q;
	logic [rbd_pkg::PIX_W-1:0]  left_q;
	logic [EXT_W-1:0]           cfg_ext;
	logic [rbd_pkg::CNT_W-1:0]  half_w, half_h;
	logic [rbd_pkg::SIZE_W-1:0] col_inc, row_inc;
	logic                       wide, tall, col_in, row_in, wr_upper, rd_upper;

	// clamp a written size into 1..MAX_SIZE
	always_comb begin
		cfg_ext = EXT_W'(cfg_data);
		if (cfg_ext == '0) begin
			size_eff = rbd_pkg::SIZE_W'(1);
		end else if (cfg_ext > EXT_W'(rbd_pkg::MAX_SIZE)) begin
			size_eff = rbd_pkg::SIZE_W'(rbd_pkg::MAX_SIZE);
		end else begin
			size_eff = rbd_pkg::SIZE_W'(cfg_ext);
		end
	end

	always_comb begin
		wide    = width_q > rbd_pkg::SIZE_W'(1);
		tall    = height_q > rbd_pkg::SIZE_W'(1);
		half_w  = wide ? width_q[rbd_pkg::SIZE_W-1:1] : rbd_pkg::CNT_W'(1);
		half_h  = tall ? height_q[rbd_pkg::SIZE_W-1:1] : rbd_pkg::CNT_W'(1);
		col_in  = rbd_pkg::CNT_W'(col_q[rbd_pkg::CNT_W-1:1]) < half_w;
		row_in  = rbd_pkg::CNT_W'(row_q[rbd_pkg::CNT_W-1:1]) < half_h;
		col_inc = rbd_pkg::SIZE_W'(col_q) + rbd_pkg::SIZE_W'(1);
		row_inc = rbd_pkg::SIZE_W'(row_q) + rbd_pkg::SIZE_W'(1);

		ctrl.emit = 1'b0;
		ctrl.last = 1'b0;
		ctrl.mode = rbd_pkg::MODE_ONE;
		wr_upper  = 1'b0;
		rd_upper  = 1'b0;
		if (wide && tall) begin
			ctrl.mode = rbd_pkg::MODE_QUAD;
			if (col_q[0] && col_in && row_in) begin
				wr_upper  = !row_q[0];
				rd_upper  = row_q[0];
				ctrl.emit = row_q[0];
				ctrl.last = (rbd_pkg::CNT_W'(col_q[rbd_pkg::CNT_W-1:1]) == half_w - 1'b1)
					&& (rbd_pkg::CNT_W'(row_q[rbd_pkg::CNT_W-1:1]) == half_h - 1'b1);
			end
		end else if (wide) begin
			ctrl.mode = rbd_pkg::MODE_HORZ;
			ctrl.emit = col_q[0] && col_in;
			ctrl.last = rbd_pkg::CNT_W'(col_q[rbd_pkg::CNT_W-1:1]) == half_w - 1'b1;
		end else if (tall) begin
			ctrl.mode = rbd_pkg::MODE_VERT;
			if (row_in) begin
				wr_upper  = !row_q[0];
				rd_upper  = row_q[0];
				ctrl.emit = row_q[0];
				ctrl.last = rbd_pkg::CNT_W'(row_q[rbd_pkg::CNT_W-1:1]) == half_h - 1'b1;
			end
		end else begin
			ctrl.emit = 1'b1;
			ctrl.last = 1'b1;
		end
	end

	always_comb begin
		mem_we   = accept && wr_upper;
		mem_re   = accept && rd_upper;
		mem_addr = (ctrl.mode == rbd_pkg::MODE_VERT) ? '0 : col_q[rbd_pkg::CNT_W-1:1];
		for (int c = 0; c < 3; c++) begin
			if (ctrl.mode == rbd_pkg::MODE_VERT) begin
				mem_wdata[c*rbd_pkg::SUM_CH_W +: rbd_pkg::SUM_CH_W] =
					rbd_pkg::SUM_CH_W'(pixel[c*rbd_pkg::CH_W +: rbd_pkg::CH_W]);
			end else begin
				mem_wdata[c*rbd_pkg::SUM_CH_W +: rbd_pkg::SUM_CH_W] =
					rbd_pkg::SUM_CH_W'(left_q[c*rbd_pkg::CH_W +: rbd_pkg::CH_W])
					+ rbd_pkg::SUM_CH_W'(pixel[c*rbd_pkg::CH_W +: rbd_pkg::CH_W]);
			end
		end
	end

	assign left_pixel = left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbd_pkg::SIZE_W'(1);
			height_q <= rbd_pkg::SIZE_W'(1);
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
		end else if (cfg_we) begin
			// any size write restarts the frame
			if (cfg_index == rbd_pkg::REG_IMAGE_WIDTH) begin
				width_q <= size_eff;
				col_q   <= '0;
				row_q   <= '0;
			end else if (cfg_index == rbd_pkg::REG_IMAGE_HEIGHT) begin
				height_q <= size_eff;
				col_q    <= '0;
				row_q    <= '0;
			end
		end else if (accept) begin
			left_q <= pixel;
			if (col_inc >= width_q) begin
				col_q <= '0;
				row_q <= (row_inc >= height_q) ? '0 : rbd_pkg::CNT_W'(row_inc);
			end else begin
				col_q <= rbd_pkg::CNT_W'(col_inc);
			end
		end
	end

endmodule

FILE: design/rgb_box_downsample_2x2.sv
// Top level of the 2x2 box-filter RGB downsampler.
//   channel | dir | handshake              | payload
//   s_axis  | in  | s_axis_tvalid/tready   | tdata: pixel_red, pixel_green, pixel_blue
//   m_axis  | out | m_axis_tvalid/tready   | tdata: out_red, out_green, out_blue; tlast: last_pixel
//   cfg     | in  | cfg_we                 | cfg_index, cfg_data (image_width, image_height)
// One pixel per clock while s_axis_tready is high; a pixel transaction's result passes the column-sum
// RAM read and middle-stage registers, then the output register.
// The upper-row column sums live in a 512 x 27 RAM, written by even rows, read by odd rows.
// Reset clears counters and sizes to 1x1; RAM contents need no clearing.
// A stalled output register holds the middle stage, and s_axis_tready drops only then.
`timescale 1ns / 1ps
module rgb_box_downsample_2x2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [23:0]                   m_axis_tdata,  // out_red, out_green, out_blue
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0]     cfg_data
);

	rbd_pkg::ctrl_t             ctrl, ctrl_s1;
	logic [rbd_pkg::PIX_W-1:0]  left_pixel, left_s1, cur_s1, result;
	logic [rbd_pkg::IDX_W-1:0]  mem_addr;
	logic [rbd_pkg::SUM_W-1:0]  mem_wdata, mem_rdata;
	logic                       mem_we, mem_re, accept, valid_s1, out_free, s1_free;
	logic [rbd_pkg::PIX_W-1:0]  out_data_q;
	logic                       out_last_q, out_valid_q;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_free       = !valid_s1 || !ctrl_s1.emit || out_free;
	assign s_axis_tready = s1_free;

	rbd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.pixel      (s_axis_tdata),
		.ctrl       (ctrl),
		.left_pixel (left_pixel),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata)
	);

	rbd_ram #(
		.WIDTH (rbd_pkg::SUM_W),
		.DEPTH (rbd_pkg::PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl;
			left_s1 <= left_pixel;
			cur_s1  <= s_axis_tdata;
		end
	end

	always_comb begin
		logic [rbd_pkg::CH_W+1:0] acc;
		for (int c = 0; c < 3; c++) begin
			acc = '0;
			unique case (ctrl_s1.mode)
				rbd_pkg::MODE_QUAD: begin
					acc = (10'(mem_rdata[c*rbd_pkg::SUM_CH_W +: rbd_pkg::SUM_CH_W])
						+ 10'(left_s1[c*rbd_pkg::CH_W +: rbd_pkg::CH_W])
						+ 10'(cur_s1[c*rbd_pkg::CH_W +: rbd_pkg::CH_W])) >> 2;
				end
				rbd_pkg::MODE_HORZ: begin
					acc = (10'(left_s1[c*rbd_pkg::CH_W +: rbd_pkg::CH_W])
						+ 10'(cur_s1[c*rbd_pkg::CH_W +: rbd_pkg::CH_W])) >> 1;
				end
				rbd_pkg::MODE_VERT: begin
					acc = (10'(mem_rdata[c*rbd_pkg::SUM_CH_W +: rbd_pkg::SUM_CH_W])
						+ 10'(cur_s1[c*rbd_pkg::CH_W +: rbd_pkg::CH_W])) >> 1;
				end
				rbd_pkg::MODE_ONE: begin
					acc = '0;
				end
				default: begin
					acc = '0;
				end
			endcase
			result[c*rbd_pkg::CH_W +: rbd_pkg::CH_W] = acc[rbd_pkg::CH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && ctrl_s1.emit) begin
			out_data_q <= result;
			out_last_q <= ctrl_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// upper-row writes and lower-row reads never share a cycle
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("column RAM read and write in the same cycle");

	// a result blocked at the output holds the middle stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctrl_s1.emit && !out_free) |=> (valid_s1 && $stable(cur_s1)))
		else $error("middle stage lost while output stalled");

	// an empty pipeline always takes a pixel
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 && !out_valid_q) |-> s_axis_tready)
		else $error("input stalled with empty pipeline");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the 2x2 RGB box downsampler.
`timescale 1ns / 1ps
module testbench;
	import rbd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam int STALL_LIMIT   = 5000;
	localparam int RANDOM_PIXELS = 500;
	localparam int DRAIN_CYCLES  = 4;

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} mip_pixel_t;

	class mip_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [SUM_W-1:0] upper_sums [PAIR_DEPTH];
		logic [PIX_W-1:0] prev_pixel;
		int unsigned      col;
		int unsigned      row;
		mip_pixel_t       expected [$];
		int unsigned      mismatches;

		function new();
			width_reg  = CFG_W'(1);
			height_reg = CFG_W'(1);
			prev_pixel = '0;
			col        = 0;
			row        = 0;
			mismatches = 0;
		endfunction

		function int unsigned eff_size(logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_SIZE)
				return MAX_SIZE;
			return 32'(v);
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Any size write restarts the frame; spare indexes are ignored.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = val;
			else if (idx == REG_IMAGE_HEIGHT)
				height_reg = val;
			else
				return;
			col = 0;
			row = 0;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] px);
			int unsigned      w;
			int unsigned      h;
			int unsigned      sw;
			int unsigned      sh;
			int unsigned      slot;
			int unsigned      tot;
			mode_t            mode;
			logic [PIX_W-1:0] avg;
			logic             emit;
			logic             last;
			mip_pixel_t       item;
			w    = eff_size(width_reg);
			h    = eff_size(height_reg);
			sw   = (w > 1) ? w / 2 : 1;
			sh   = (h > 1) ? h / 2 : 1;
			slot = (col / 2) % PAIR_DEPTH;
			avg  = '0;
			emit = 1'b0;
			last = 1'b0;
			if (w > 1 && h > 1)
				mode = MODE_QUAD;
			else if (w > 1)
				mode = MODE_HORZ;
			else if (h > 1)
				mode = MODE_VERT;
			else
				mode = MODE_ONE;
			case (mode)
				MODE_QUAD: begin
					if (col % 2 == 1 && col / 2 < sw && row / 2 < sh) begin
						for (int c = 0; c < 3; c++) begin
							if (row % 2 == 0) begin
								upper_sums[slot][SUM_CH_W*c +: SUM_CH_W] =
									SUM_CH_W'(prev_pixel[CH_W*c +: CH_W]) +
									SUM_CH_W'(px[CH_W*c +: CH_W]);
							end else begin
								tot = 32'(upper_sums[slot][SUM_CH_W*c +: SUM_CH_W]) +
									32'(prev_pixel[CH_W*c +: CH_W]) +
									32'(px[CH_W*c +: CH_W]);
								avg[CH_W*c +: CH_W] = CH_W'(tot >> 2);
							end
						end
						if (row % 2 == 1) begin
							emit = 1'b1;
							last = (col / 2 == sw - 1) && (row / 2 == sh - 1);
						end
					end
				end
				MODE_HORZ: begin
					if (col % 2 == 1 && col / 2 < sw) begin
						for (int c = 0; c < 3; c++) begin
							tot = 32'(prev_pixel[CH_W*c +: CH_W]) + 32'(px[CH_W*c +: CH_W]);
							avg[CH_W*c +: CH_W] = CH_W'(tot >> 1);
						end
						emit = 1'b1;
						last = (col / 2 == sw - 1);
					end
				end
				MODE_VERT: begin
					if (row / 2 < sh) begin
						for (int c = 0; c < 3; c++) begin
							if (row % 2 == 0) begin
								upper_sums[0][SUM_CH_W*c +: SUM_CH_W] = {1'b0, px[CH_W*c +: CH_W]};
							end else begin
								tot = 32'(upper_sums[0][SUM_CH_W*c +: SUM_CH_W]) +
									32'(px[CH_W*c +: CH_W]);
								avg[CH_W*c +: CH_W] = CH_W'(tot >> 1);
							end
						end
						if (row % 2 == 1) begin
							emit = 1'b1;
							last = (row / 2 == sh - 1);
						end
					end
				end
				default: begin
					// single pixel image yields black
					emit = 1'b1;
					last = 1'b1;
				end
			endcase
			prev_pixel = px;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h)
					row = 0;
			end
			if (emit) begin
				item.red   = avg[7:0];
				item.green = avg[15:8];
				item.blue  = avg[23:16];
				item.last  = last;
				expected.push_back(item);
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] data, logic last);
			mip_pixel_t want;
			if (expected.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: r %0d g %0d b %0d last %0d",
						data[7:0], data[15:8], data[23:16], last);
				mismatches++;
				return;
			end
			want = expected.pop_front();
			if (want.red !== data[7:0] || want.green !== data[15:8] ||
				want.blue !== data[23:16] || want.last !== last) begin
				if (mismatches < 10)
					$display({"mismatch: expected r %0d g %0d b %0d last %0d, ",
						"got r %0d g %0d b %0d last %0d"},
						want.red, want.green, want.blue, want.last,
						data[7:0], data[15:8], data[23:16], last);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [PIX_W-1:0]     s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [PIX_W-1:0]     m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int            tx_idle_pct;
	int            rx_idle_pct;
	mip_scoreboard sb;

	rgb_box_downsample_2x2 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast);
	end

	// End the run if no transaction moves on either side for too long.
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall = 0;
			else
				stall++;
		end
		$display("FAIL rgb_box_downsample_2x2");
		$finish;
	end

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] px;
		px = PIX_W'($urandom);
		for (int c = 0; c < 3; c++) begin
			case ($urandom_range(7))
				0: px[CH_W*c +: CH_W] = 8'h00;
				1: px[CH_W*c +: CH_W] = 8'hFF;
				default: ;
			endcase
		end
		return px;
	endfunction

	// Hold off until the pipeline is empty, then write one register.
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic configure(int w, int h);
		if ($urandom_range(4) == 0)
			set_reg(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
		if ($urandom_range(1) == 1) begin
			set_reg(REG_IMAGE_WIDTH, CFG_W'(w));
			set_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		end else begin
			set_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
			set_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		end
	endtask

	task automatic send_pixel(logic [PIX_W-1:0] px);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(px);
	endtask

	task automatic send_pixels(int n);
		repeat (n) send_pixel(random_pixel());
	endtask

	initial begin
		int w;
		int h;
		int frame;
		int npix;
		int kind;
		int rnd_pixels;
		sb            = new();
		tx_idle_pct   = 35;
		rx_idle_pct   = 75;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sizes after reset: 1x1, every pixel gives a black last pixel
		send_pixel('1);
		send_pixel('0);
		// zero sizes count as one
		set_reg(REG_IMAGE_WIDTH, '0);
		set_reg(REG_IMAGE_HEIGHT, '0);
		send_pixel(random_pixel());
		// full-scale quad exercises the top bit of the column sums
		set_reg(REG_IMAGE_WIDTH, CFG_W'(2));
		set_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		repeat (4) send_pixel('1);
		// one row high, odd last column dropped
		set_reg(REG_IMAGE_WIDTH, CFG_W'(3));
		set_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
		send_pixel('1);
		send_pixel('0);
		send_pixel(random_pixel());
		// one column wide, odd last row dropped
		set_reg(REG_IMAGE_WIDTH, CFG_W'(1));
		set_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
		send_pixel('1);
		send_pixel('1);
		send_pixel(random_pixel());
		// spare indexes mid-frame leave the position alone
		set_reg(REG_IMAGE_WIDTH, CFG_W'(4));
		set_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		send_pixels(3);
		set_reg(REG_SPARE_A, CFG_W'($urandom));
		set_reg(REG_SPARE_B, CFG_W'($urandom));
		send_pixels(5);
		// a size write mid-frame restarts the frame
		set_reg(REG_IMAGE_WIDTH, CFG_W'(2));
		set_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		send_pixels(2);
		set_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		send_pixels(4);

		// largest sizes: one full wide row, then partial frames
		configure(MAX_SIZE, 1);
		send_pixels(MAX_SIZE);
		configure(2, MAX_SIZE);
		send_pixels($urandom_range(40, 80));
		configure(MAX_SIZE, MAX_SIZE);
		send_pixels($urandom_range(20, 40));

		rnd_pixels = 0;
		while (rnd_pixels < RANDOM_PIXELS) begin
			if (rnd_pixels < RANDOM_PIXELS / 3) begin
				tx_idle_pct = 35;
				rx_idle_pct = 75;
			end else if (rnd_pixels < 2 * RANDOM_PIXELS / 3) begin
				tx_idle_pct = 75;
				rx_idle_pct = 35;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			kind = $urandom_range(99);
			if (kind < 6) begin
				// width above range clamps; never finish such a frame
				w    = $urandom_range(MAX_SIZE + 1, 2047);
				h    = $urandom_range(1, 3);
				npix = $urandom_range(20, 80);
			end else if (kind < 12) begin
				w    = $urandom_range(1, 4);
				h    = $urandom_range(MAX_SIZE + 1, 2047);
				npix = $urandom_range(20, 80);
			end else begin
				if (kind < 20) begin
					w = ($urandom_range(1) == 1) ? 0 : $urandom_range(1, 6);
					h = (w == 0) ? $urandom_range(0, 6) : 0;
				end else begin
					w = $urandom_range(1, 9);
					h = $urandom_range(1, 9);
				end
				frame = sb.eff_size(CFG_W'(w)) * sb.eff_size(CFG_W'(h));
				npix  = $urandom_range(1, 3) * frame;
				if ($urandom_range(6) == 0)
					npix = $urandom_range(1, frame);
			end
			configure(w, h);
			send_pixels(npix);
			rnd_pixels += npix;
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS rgb_box_downsample_2x2");
		else
			$display("FAIL rgb_box_downsample_2x2");
		$finish;
	end

endmodule
